// File: hdl/sfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared constants and helpers for the SBUS frame decoder.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int unsigned CHANNEL_COUNT_DEF = 16;
  localparam int unsigned CHAN_WIDTH        = 11;

  localparam logic [7:0] HEADER_BYTE  = 8'h0F;
  localparam logic [7:0] FOOTER_BYTE  = 8'h00;
  localparam logic [3:0] SBUS2_FOOTER = 4'h4;

  localparam int unsigned FLAG_LOST_BIT     = 2;
  localparam int unsigned FLAG_FAILSAFE_BIT = 3;

  // Plain SBUS footer, or any SBUS2 footer (low nibble 0x4)
  function automatic logic is_footer(input logic [7:0] b);
    return (b == FOOTER_BYTE) || (b[3:0] == SBUS2_FOOTER);
  endfunction

endpackage : sfd_pkg
`default_nettype wire

// File: hdl/sfd_chan_emit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_chan_emit
// Holds one completed frame and hands out its channels one request at a time.
// ----------------------------------------------------------------------------
module sfd_chan_emit #(
  parameter int unsigned CHANNEL_COUNT = sfd_pkg::CHANNEL_COUNT_DEF
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst,
  input  wire logic                                         load,
  input  wire logic [CHANNEL_COUNT*sfd_pkg::CHAN_WIDTH-1:0] frame_data,
  input  wire logic                                         failsafe_in,
  input  wire logic                                         lost_in,
  output logic                                              out_valid,
  input  wire logic                                         out_ready,
  output logic [$clog2(CHANNEL_COUNT)-1:0]                  channel_index,
  output logic [sfd_pkg::CHAN_WIDTH-1:0]                    channel_value,
  output logic                                              failsafe,
  output logic                                              lost_frame,
  output logic                                              last_of_frame
);
  import sfd_pkg::*;

  localparam int unsigned DataBits = CHANNEL_COUNT * CHAN_WIDTH;
  localparam int unsigned IdxWidth = $clog2(CHANNEL_COUNT);
  localparam logic [IdxWidth-1:0] LastIdx = IdxWidth'(CHANNEL_COUNT - 1);

  logic [DataBits-1:0] snap;
  logic [IdxWidth-1:0] index;
  logic                take;

  assign take          = out_valid && out_ready;
  assign last_of_frame = (index == LastIdx);
  assign channel_index = index;
  assign channel_value = snap[CHAN_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      index     <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      index     <= '0;
    end else if (take) begin
      if (last_of_frame) begin
        out_valid <= 1'b0;
      end
      index <= index + 1'b1;
    end
  end

  // Payload: load the frame, then shift the next channel down to the bottom
  always_ff @(posedge clk) begin
    if (load) begin
      snap       <= frame_data;
      failsafe   <= failsafe_in;
      lost_frame <= lost_in;
    end else if (take) begin
      snap <= snap >> CHAN_WIDTH;
    end
  end

endmodule : sfd_chan_emit
`default_nettype wire

// File: hdl/sbus_frame_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbus_frame_decoder
// SBUS / SBUS2 receive frame decoder: bytes in, one request per channel out.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+-----------------------------------------
//  in      | in_valid / in_ready     | rx_byte
//  out     | out_valid / out_ready   | channel_index, channel_value, failsafe,
//          |                         | lost_frame, last_of_frame
//
// A byte is taken while in_valid and in_ready are high; header, data and footer
// handling is a single registered pass. A good footer yields CHANNEL_COUNT
// results, one a cycle while out_ready is high, from the channel buffer. Data
// bytes of the next frame are taken while the buffer drains; only a footer
// waits for it. rst is synchronous and returns the decoder to header hunting.
// ----------------------------------------------------------------------------
module sbus_frame_decoder #(
  parameter int unsigned CHANNEL_COUNT = sfd_pkg::CHANNEL_COUNT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [7:0]                        rx_byte,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [$clog2(CHANNEL_COUNT)-1:0]       channel_index,
  output logic [sfd_pkg::CHAN_WIDTH-1:0]         channel_value,
  output logic                                   failsafe,
  output logic                                   lost_frame,
  output logic                                   last_of_frame
);
  import sfd_pkg::*;

  localparam int unsigned DataBits  = CHANNEL_COUNT * CHAN_WIDTH;
  localparam int unsigned DataBytes = (DataBits + 7) / 8;
  localparam int unsigned StoreBits = (DataBytes + 1) * 8;
  localparam int unsigned FooterPos = DataBytes + 2;
  localparam int unsigned PosWidth  = $clog2(FooterPos + 1);
  localparam logic [PosWidth-1:0] FooterIdx = PosWidth'(FooterPos);

  logic [PosWidth-1:0]  position;
  logic [PosWidth-1:0]  position_next;
  logic [7:0]           previous_byte;
  logic [StoreBits-1:0] store;
  logic                 accept;
  logic                 load;
  logic [7:0]           flags;

  // Hold a footer until the previous frame has fully drained
  assign in_ready = !((position == FooterIdx) && out_valid);
  assign accept   = in_valid && in_ready;
  assign flags    = store[StoreBits-1 -: 8];
  assign load     = accept && (position == FooterIdx) && is_footer(rx_byte);

  always_comb begin
    position_next = position;
    if (position == '0) begin
      if (rx_byte == HEADER_BYTE && is_footer(previous_byte)) begin
        position_next = PosWidth'(1);
      end
    end else if (position < FooterIdx) begin
      position_next = position + 1'b1;
    end else begin
      position_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= '0;
      previous_byte <= FOOTER_BYTE;
    end else if (accept) begin
      position      <= position_next;
      previous_byte <= rx_byte;
    end
  end

  // Shift data bytes in from the top: first byte ends at the bottom
  always_ff @(posedge clk) begin
    if (accept && position != '0 && position < FooterIdx) begin
      store <= {rx_byte, store[StoreBits-1:8]};
    end
  end

  sfd_chan_emit #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_emit (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .frame_data    (store[DataBits-1:0]),
    .failsafe_in   (flags[FLAG_FAILSAFE_BIT]),
    .lost_in       (flags[FLAG_LOST_BIT]),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .failsafe      (failsafe),
    .lost_frame    (lost_frame),
    .last_of_frame (last_of_frame)
  );

endmodule : sbus_frame_decoder
`default_nettype wire

// File: tb/sbus_frame_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbus_frame_decoder_tb
// Self-checking bench for the SBUS frame decoder. Bytes go in on a bursty
// valid/ready sender and channel requests come back through a stalling
// receiver. A cycle-free decoder model predicts every channel request, and
// each one is compared field by field in order of arrival.
// ----------------------------------------------------------------------------
module sbus_frame_decoder_tb;
  import sfd_pkg::*;

  localparam int unsigned NUM_CHANNELS   = 16;
  localparam int unsigned DATA_BYTES     = 22;
  localparam int unsigned STORE_DEPTH    = 23;
  localparam logic [4:0]  POS_HUNT       = 5'd0;
  localparam logic [4:0]  POS_FOOTER     = 5'd24;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned MAX_REPORTS    = 40;
  localparam int unsigned RANDOM_FRAMES  = 10;

  typedef enum int {FOOT_PLAIN, FOOT_SBUS2, FOOT_BAD} footer_kind_e;
  typedef enum int {READY_ALWAYS, READY_PATTERN, READY_RANDOM} ready_mode_e;

  typedef struct packed {
    logic [3:0]            index;
    logic [CHAN_WIDTH-1:0] value;
    logic                  fs;
    logic                  lost;
    logic                  last;
  } chan_result_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic [7:0]            rx_byte   = 8'h00;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [3:0]            channel_index;
  logic [CHAN_WIDTH-1:0] channel_value;
  logic                  failsafe;
  logic                  lost_frame;
  logic                  last_of_frame;

  // decoder model state
  logic [4:0]   frame_pos;
  logic [7:0]   prev_rx;
  logic [7:0]   frame_bytes [STORE_DEPTH];
  chan_result_t pending_channels [$];

  int unsigned mismatches  = 0;
  int unsigned results_in  = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left  = 0;

  ready_mode_e ready_mode    = READY_ALWAYS;
  logic [15:0] ready_pattern = 16'hFFFF;
  int unsigned ready_phase   = 0;
  int unsigned mode_left     = 0;

  sbus_frame_decoder #(
    .CHANNEL_COUNT(NUM_CHANNELS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .channel_index(channel_index),
    .channel_value(channel_value),
    .failsafe     (failsafe),
    .lost_frame   (lost_frame),
    .last_of_frame(last_of_frame)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic footer_like(input logic [7:0] b);
    return (b == FOOTER_BYTE) || (b[3:0] == SBUS2_FOOTER);
  endfunction

  // Advance the model by one accepted byte; a good footer queues 16 channels.
  function automatic void decode_byte(input logic [7:0] b);
    logic [8*DATA_BYTES-1:0] stream;
    logic [7:0]              flags;
    chan_result_t            res;
    int unsigned             ch;
    if (frame_pos == POS_HUNT) begin
      if (b == HEADER_BYTE && footer_like(prev_rx))
        frame_pos = 5'd1;
    end else if (frame_pos < POS_FOOTER) begin
      frame_bytes[frame_pos - 5'd1] = b;
      frame_pos = frame_pos + 5'd1;
    end else begin
      if (frame_pos == POS_FOOTER && footer_like(b)) begin
        for (int i = 0; i < DATA_BYTES; i++)
          stream[8*i +: 8] = frame_bytes[i];
        flags = frame_bytes[STORE_DEPTH-1];
        for (ch = 0; ch < NUM_CHANNELS; ch++) begin
          res.index = ch[3:0];
          res.value = stream[CHAN_WIDTH*ch +: CHAN_WIDTH];
          res.fs    = flags[FLAG_FAILSAFE_BIT];
          res.lost  = flags[FLAG_LOST_BIT];
          res.last  = (ch == NUM_CHANNELS - 1);
          pending_channels.push_back(res);
        end
      end
      frame_pos = POS_HUNT;
    end
    prev_rx = b;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_REPORTS)
      $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(input string field, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("request %0d %s: got %0h, expected %0h",
                                results_in, field, got, want));
  endtask

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      decode_byte(rx_byte);
  end

  always @(posedge clk) begin : check_results
    chan_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_channels.size() == 0) begin
        report_mismatch($sformatf("request %0d with none expected: ch %0d value %0h",
                                  results_in, channel_index, channel_value));
      end else begin
        want = pending_channels.pop_front();
        check_field("channel_index", 16'(channel_index), 16'(want.index));
        check_field("channel_value", 16'(channel_value), 16'(want.value));
        check_field("failsafe", 16'(failsafe), 16'(want.fs));
        check_field("lost_frame", 16'(lost_frame), 16'(want.lost));
        check_field("last_of_frame", 16'(last_of_frame), 16'(want.last));
      end
      results_in++;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
        $display("** sbus_frame_decoder: FAILED **");
        $finish;
      end
    end
  end

  // Receiver: switch between always ready, a rotating stall pattern and random draws (ready three in four).
  always @(negedge clk) begin
    if (mode_left == 0) begin
      ready_mode    = ready_mode_e'($urandom_range(0, 2));
      mode_left     = $urandom_range(20, 200);
      ready_pattern = 16'($urandom_range(1, 16'hFFFF));
    end
    mode_left--;
    ready_phase++;
    case (ready_mode)
      READY_ALWAYS:  out_ready <= 1'b1;
      READY_PATTERN: out_ready <= ready_pattern[ready_phase[3:0]];
      default:       out_ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Drive one byte at the falling edge and hold it until taken; returns at a
  // falling edge so the model has already seen the byte.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 24);
      gap = $urandom_range(1, 20);
      in_valid <= 1'b0;
      rx_byte  <= 8'($urandom_range(0, 255));
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    burst_left--;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_frame(input footer_kind_e kind);
    logic [7:0]  foot;
    logic [3:0]  upper;
    int unsigned style;
    // close any frame that stray bytes happened to open
    while (frame_pos != POS_HUNT)
      send_byte(FOOTER_BYTE);
    upper = 4'($urandom_range(0, 15));
    if (!footer_like(prev_rx))
      send_byte($urandom_range(0, 1) ? FOOTER_BYTE : {upper, SBUS2_FOOTER});
    send_byte(HEADER_BYTE);
    style = $urandom_range(0, 7);
    for (int i = 0; i < DATA_BYTES; i++) begin
      case (style)
        0:       send_byte(8'hFF);
        1:       send_byte(8'h00);
        default: send_byte(($urandom_range(0, 7) == 0) ? HEADER_BYTE
                                                       : 8'($urandom_range(0, 255)));
      endcase
    end
    send_byte(8'($urandom_range(0, 255)));
    upper = 4'($urandom_range(0, 15));
    case (kind)
      FOOT_PLAIN: foot = FOOTER_BYTE;
      FOOT_SBUS2: foot = {upper, SBUS2_FOOTER};
      default: begin
        do foot = 8'($urandom_range(0, 255)); while (footer_like(foot));
      end
    endcase
    send_byte(foot);
  endtask

  task automatic test_first_frame();
    // previous byte resets to a footer, so this header opens a frame
    send_byte(HEADER_BYTE);
    repeat (11) send_byte(8'hFF);
    send_byte(HEADER_BYTE);
    repeat (10) send_byte(8'h00);
    send_byte(8'h0C);
    send_byte(8'hF4);
  endtask

  task automatic test_bad_footer();
    send_frame(FOOT_BAD);
    // previous byte is the bad footer, so this header must be ignored
    send_byte(HEADER_BYTE);
  endtask

  task automatic test_hunting();
    repeat (16)
      send_byte(($urandom_range(0, 2) == 0) ? HEADER_BYTE : 8'($urandom_range(0, 255)));
    send_byte(8'h84);
    send_byte(HEADER_BYTE);
    while (frame_pos != POS_HUNT)
      send_byte(FOOTER_BYTE);
  endtask

  task automatic test_random_frames(input int unsigned count);
    int unsigned pick;
    repeat (count) begin
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 4))
          send_byte(($urandom_range(0, 3) == 0) ? HEADER_BYTE : 8'($urandom_range(0, 255)));
      pick = $urandom_range(0, 99);
      send_frame(pick < 40 ? FOOT_PLAIN : (pick < 75 ? FOOT_SBUS2 : FOOT_BAD));
    end
  endtask

  initial begin
    frame_pos = POS_HUNT;
    prev_rx   = FOOTER_BYTE;
    for (int i = 0; i < STORE_DEPTH; i++)
      frame_bytes[i] = 8'h00;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_first_frame();
    test_bad_footer();
    test_hunting();
    test_random_frames(RANDOM_FRAMES);
    in_valid <= 1'b0;

    while (pending_channels.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("** sbus_frame_decoder: PASSED **");
    else
      $display("** sbus_frame_decoder: FAILED **");
    $finish;
  end

endmodule

// File: files.f
hdl/sfd_pkg.sv
hdl/sfd_chan_emit.sv
hdl/sbus_frame_decoder.sv
tb/sbus_frame_decoder_tb.sv
